// ===== hdl/uga_pkg.sv =====
// uga_pkg: shared types, constants and lookup functions of the utf8 glyph address mapper
// used by uga_controller, uga_datapath and utf8_glyph_address_mapper_core
// depends on nothing
`default_nettype none

package uga_pkg;

	// default parameter values
	localparam int ADDRESS_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF   = 16;

	// port and field widths
	localparam int BYTE_W       = 8;
	localparam int DIM_W        = 7;
	localparam int BASE_W       = 32;
	localparam int INDEX_W      = 7;
	localparam int OUT_COUNT_W  = 16;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int AREA_W       = 2 * DIM_W;
	localparam int PROD_W       = INDEX_W + AREA_W;
	localparam int OUT_DATA_W   = 56;
	localparam int OUT_USER_W   = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ASCII_TABLE_BASE = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_TABLE_BASE = 2'd3;

	// configuration reset values
	localparam logic [DIM_W-1:0] GLYPH_DIM_RESET = 7'd8;

	// byte values
	localparam logic [BYTE_W-1:0] ASCII_FIRST    = 8'd32;
	localparam logic [BYTE_W-1:0] ASCII_LAST     = 8'd126;
	localparam logic [BYTE_W-1:0] BYTE_NUL       = 8'h00;
	localparam logic [BYTE_W-1:0] INF_LEAD       = 8'he2;
	localparam logic [BYTE_W-1:0] INF_SECOND     = 8'h88;
	localparam logic [BYTE_W-1:0] INF_THIRD      = 8'h9e;
	localparam logic [INDEX_W-1:0] QMARK_INDEX   = 7'd31;
	localparam logic [INDEX_W-1:0] INF_INDEX     = 7'd18;

	// two-byte extra glyphs, lead byte in the high half
	localparam int PAIR_COUNT = 18;
	localparam logic [15:0] PAIR_TABLE [PAIR_COUNT] = '{
		16'hc484, 16'hc486, 16'hc498, 16'hc581, 16'hc583,
		16'hc393, 16'hc59a, 16'hc5b9, 16'hc5bb, 16'hc485,
		16'hc487, 16'hc499, 16'hc582, 16'hc584, 16'hc3b3,
		16'hc59b, 16'hc5ba, 16'hc5bc
	};

	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] index;
	} pair_hit_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic load_area;
		logic load_prod;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic produces;
	} dp_status_t;

	// character length from the lead byte
	function automatic logic [2:0] char_length(input logic [BYTE_W-1:0] b);
		logic [2:0] len;
		if (!b[7]) begin
			len = 3'd1;
		end else if (!b[5]) begin
			len = 3'd2;
		end else if (!b[4]) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

	// first matching two-byte extra glyph
	function automatic pair_hit_t pair_lookup(input logic [BYTE_W-1:0] lead,
	                                          input logic [BYTE_W-1:0] second);
		pair_hit_t r;
		r.hit   = 1'b0;
		r.index = '0;
		for (int k = PAIR_COUNT - 1; k >= 0; k--) begin
			if (PAIR_TABLE[k] == {lead, second}) begin
				r.hit   = 1'b1;
				r.index = INDEX_W'(k);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/uga_datapath.sv =====
// uga_datapath: configuration registers, character assembly, glyph selection,
// address multiply and add, and the output register
// depends on uga_pkg
`default_nettype none

module uga_datapath #(
	parameter int ADDRESS_BITS = uga_pkg::ADDRESS_BITS_DEF,
	parameter int COUNT_BITS   = uga_pkg::COUNT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [uga_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [uga_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [uga_pkg::BYTE_W-1:0]      text_byte,
	input  wire uga_pkg::ctrl_cmd_t              cmd,
	output uga_pkg::dp_status_t                  status,
	output logic [uga_pkg::BASE_W-1:0]           glyph_address,
	output logic [uga_pkg::INDEX_W-1:0]          glyph_index,
	output logic                                 from_extra_table,
	output logic                                 replaced_unknown,
	output logic                                 string_end,
	output logic [uga_pkg::OUT_COUNT_W-1:0]      char_count
);
	import uga_pkg::*;

	localparam logic [BASE_W-1:0] ADDR_MASK =
		(ADDRESS_BITS >= BASE_W) ? {BASE_W{1'b1}} : BASE_W'((64'd1 << ADDRESS_BITS) - 64'd1);

	// configuration registers
	logic [DIM_W-1:0]  height_q, width_q;
	logic [BASE_W-1:0] ascii_base_q, extra_base_q;

	// assembly state
	logic [2:0]            needed_q;
	logic [1:0]            seen_q;
	logic [BYTE_W-1:0]     lead_q, second_q;
	logic [COUNT_BITS-1:0] count_q;

	// captured result of the current item
	logic [INDEX_W-1:0]     idx_q;
	logic [BASE_W-1:0]      base_q;
	logic                   extra_q, repl_q, end_q;
	logic [OUT_COUNT_W-1:0] cnt_out_q;
	logic [AREA_W-1:0]      area_q;
	logic [PROD_W-1:0]      prod_q;

	// next-state and result logic
	logic [2:0]            nxt_needed, len;
	logic [1:0]            nxt_seen;
	logic [2:0]            seen_inc;
	logic [BYTE_W-1:0]     nxt_lead, nxt_second, second_eff;
	logic                  produces, is_end, ascii_ok, extra_hit;
	logic [INDEX_W-1:0]    extra_idx, res_idx;
	logic [BASE_W-1:0]     res_base;
	logic                  res_repl;
	logic [COUNT_BITS-1:0] nxt_count;
	logic [OUT_COUNT_W-1:0] res_cnt;
	logic [BASE_W:0]       addr_sum;
	pair_hit_t             ph;

	assign len        = char_length(text_byte);
	assign second_eff = (seen_q == 2'd1) ? text_byte : second_q;
	assign ph         = pair_lookup(lead_q, second_eff);
	assign seen_inc   = {1'b0, seen_q} + 3'd1;

	// character assembly
	always_comb begin
		nxt_needed = needed_q;
		nxt_seen   = seen_q;
		nxt_lead   = lead_q;
		nxt_second = second_q;
		produces   = 1'b0;
		is_end     = 1'b0;
		ascii_ok   = 1'b0;
		extra_hit  = 1'b0;
		extra_idx  = '0;
		if (needed_q == 3'd0) begin
			if (text_byte == BYTE_NUL) begin
				produces = 1'b1;
				is_end   = 1'b1;
			end else if (len == 3'd1) begin
				produces = 1'b1;
				ascii_ok = (text_byte >= ASCII_FIRST) && (text_byte <= ASCII_LAST);
			end else begin
				nxt_lead   = text_byte;
				nxt_needed = len;
				nxt_seen   = 2'd1;
			end
		end else begin
			nxt_second = second_eff;
			if (seen_inc < needed_q) begin
				nxt_seen = seen_inc[1:0];
			end else begin
				produces   = 1'b1;
				nxt_needed = 3'd0;
				nxt_seen   = 2'd0;
				if (needed_q == 3'd2 && ph.hit) begin
					extra_hit = 1'b1;
					extra_idx = ph.index;
				end else if (needed_q == 3'd3 && lead_q == INF_LEAD &&
				             second_eff == INF_SECOND && text_byte == INF_THIRD) begin
					extra_hit = 1'b1;
					extra_idx = INF_INDEX;
				end
			end
		end
	end

	// glyph selection and character count
	always_comb begin
		res_repl  = 1'b0;
		nxt_count = count_q;
		res_cnt   = OUT_COUNT_W'(count_q);
		if (is_end) begin
			res_idx   = '0;
			res_base  = '0;
			nxt_count = '0;
		end else begin
			if (extra_hit) begin
				res_idx  = extra_idx;
				res_base = extra_base_q;
			end else if (ascii_ok) begin
				res_idx  = INDEX_W'(text_byte - ASCII_FIRST);
				res_base = ascii_base_q;
			end else begin
				res_idx  = QMARK_INDEX;
				res_repl = 1'b1;
				res_base = ascii_base_q;
			end
			if (count_q != {COUNT_BITS{1'b1}}) begin
				nxt_count = count_q + COUNT_BITS'(1);
			end
			res_cnt = OUT_COUNT_W'(nxt_count);
		end
	end

	assign status.produces = produces;
	assign addr_sum        = {1'b0, base_q} + (BASE_W + 1)'(prod_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q     <= GLYPH_DIM_RESET;
			width_q      <= GLYPH_DIM_RESET;
			ascii_base_q <= '0;
			extra_base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GLYPH_HEIGHT:     height_q     <= cfg_data[DIM_W-1:0];
				REG_GLYPH_WIDTH:      width_q      <= cfg_data[DIM_W-1:0];
				REG_ASCII_TABLE_BASE: ascii_base_q <= cfg_data[BASE_W-1:0];
				REG_EXTRA_TABLE_BASE: extra_base_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// assembly state and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= '0;
			seen_q   <= '0;
			lead_q   <= '0;
			second_q <= '0;
			count_q  <= '0;
		end else if (cmd.accept) begin
			needed_q <= nxt_needed;
			seen_q   <= nxt_seen;
			lead_q   <= nxt_lead;
			second_q <= nxt_second;
			if (produces) begin
				count_q <= nxt_count;
			end
		end
	end

	// result capture, multiply steps and output register
	always_ff @(posedge clk) begin
		if (cmd.accept && produces) begin
			idx_q     <= res_idx;
			base_q    <= res_base;
			extra_q   <= extra_hit && !is_end;
			repl_q    <= res_repl;
			end_q     <= is_end;
			cnt_out_q <= res_cnt;
		end
		if (cmd.load_area) begin
			area_q <= AREA_W'(height_q) * AREA_W'(width_q);
		end
		if (cmd.load_prod) begin
			prod_q <= PROD_W'(idx_q) * PROD_W'(area_q);
		end
		if (cmd.load_out) begin
			glyph_address    <= addr_sum[BASE_W-1:0] & ADDR_MASK;
			glyph_index      <= idx_q;
			from_extra_table <= extra_q;
			replaced_unknown <= repl_q;
			string_end       <= end_q;
			char_count       <= cnt_out_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/uga_controller.sv =====
// uga_controller: sequencer over accept, area multiply, index multiply and emit,
// and the output valid flag
// depends on uga_pkg
`default_nettype none

module uga_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	input  wire uga_pkg::dp_status_t  status,
	output uga_pkg::ctrl_cmd_t        cmd
);
	import uga_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_MUL_HW  = 4'b0010,
		ST_MUL_IDX = 4'b0100,
		ST_EMIT    = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	// commands to the datapath
	assign cmd.accept    = s_tvalid && s_tready;
	assign cmd.load_area = (state_q == ST_MUL_HW);
	assign cmd.load_prod = (state_q == ST_MUL_IDX);
	assign cmd.load_out  = (state_q == ST_EMIT) && slot_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.produces) begin
					state_d = ST_MUL_HW;
				end
			end
			ST_MUL_HW:  state_d = ST_MUL_IDX;
			ST_MUL_IDX: state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// a byte that completes an item reaches emit after the two multiply steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && status.produces) |-> ##3 (state_q == ST_EMIT))
		else $error("result item did not reach emit");

	// a byte that completes nothing leaves the sequencer ready for the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !status.produces) |=> (state_q == ST_IDLE))
		else $error("partial character left the sequencer busy");

	// a finished result waits in emit while the output slot is held
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && m_tvalid && !m_tready) |=> (state_q == ST_EMIT && m_tvalid))
		else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/utf8_glyph_address_mapper_core.sv =====
// utf8_glyph_address_mapper_core: top level of the utf8 glyph address mapper
// depends on uga_pkg, uga_controller and uga_datapath
//
// usage
//   input stream (s_*): one raw utf-8 text byte per transaction in s_tdata.
//   output stream (m_*): one glyph transaction per complete character, and one
//   with m_tlast set when a zero lead byte ends the string; that transaction
//   carries the character count and zero glyph fields, then the count clears.
//   configuration: cfg_we writes cfg_data to register cfg_index at a clock edge
//   (0 glyph height, 1 glyph width, 2 ascii table base, 3 extra table base);
//   write only while no character is in flight.
// sequence
//   after a byte that does not complete a character the next byte may follow
//   at once. a byte that completes a character or ends the string is followed
//   by the area multiply, the index multiply and the add, which loads the
//   output register; s_tready stays low during those steps, so the next byte
//   is taken only once the result is in the output register.
// stall and reset
//   a result held by a stalled receiver stays in the output register; the next
//   byte is still taken, and a second result waits in the emit step until the
//   register frees. reset clears the count and partial character and loads
//   height and width 8 and zero bases.
`default_nettype none

module utf8_glyph_address_mapper_core #(
	parameter int ADDRESS_BITS = uga_pkg::ADDRESS_BITS_DEF,
	parameter int COUNT_BITS   = uga_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [uga_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [uga_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [uga_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] text_byte
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [31:0] glyph_address, [38:32] glyph_index, [54:39] char_count, [55] zero
	output logic [uga_pkg::OUT_DATA_W-1:0]        m_tdata,
	// [0] from_extra_table, [1] replaced_unknown
	output logic [uga_pkg::OUT_USER_W-1:0]        m_tuser,
	output logic                                  m_tlast   // string_end
);
	import uga_pkg::*;

	ctrl_cmd_t              cmd;
	dp_status_t             status;
	logic [BASE_W-1:0]      glyph_address;
	logic [INDEX_W-1:0]     glyph_index;
	logic                   from_extra_table, replaced_unknown, string_end;
	logic [OUT_COUNT_W-1:0] char_count;

	uga_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	uga_datapath #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.COUNT_BITS   (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.text_byte        (s_tdata),
		.cmd              (cmd),
		.status           (status),
		.glyph_address    (glyph_address),
		.glyph_index      (glyph_index),
		.from_extra_table (from_extra_table),
		.replaced_unknown (replaced_unknown),
		.string_end       (string_end),
		.char_count       (char_count)
	);

	// output packing
	assign m_tdata = {1'b0, char_count, glyph_index, glyph_address};
	assign m_tuser = {replaced_unknown, from_extra_table};
	assign m_tlast = string_end;

endmodule

`default_nettype wire

// ===== dv/tb_utf8_glyph_address_mapper_core.sv =====
// tb_utf8_glyph_address_mapper_core: self-checking testbench of the utf8 glyph address mapper
// drives text bytes with random gaps, predicts each glyph transaction and compares field by field
// depends on uga_pkg and utf8_glyph_address_mapper_core
`timescale 1ns / 1ps

module tb_utf8_glyph_address_mapper_core;

	import uga_pkg::*;

	localparam int CYCLE_LIMIT  = 200_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_TICKS = 12;
	localparam int LONG_CHARS   = 60;

	// short text covering the table edges, every extra glyph kind and malformed characters
	localparam logic [7:0] DIRECTED_TEXT [25] = '{
		8'h00,                          // empty string, count zero
		8'h20, 8'h7e, 8'h1f, 8'h7f,     // printable bounds, control and delete
		8'hc4, 8'h84, 8'hc5, 8'hbc,     // first and last polish pair
		8'hc3, 8'hb3,
		8'hc4, 8'h80,                   // two-byte character with no glyph
		8'he2, 8'h88, 8'h9e,            // infinity sign
		8'hf0, 8'h9f, 8'h98, 8'h80,     // four-byte character
		8'hc4, 8'h00,                   // zero inside a character
		8'h80, 8'h41,                   // continuation byte used as a lead
		8'h00                           // end of string with count
	};

	typedef struct packed {
		logic [31:0] address;
		logic [6:0]  index;
		logic [15:0] count;
		logic        extra;
		logic        replaced;
		logic        string_end;
	} glyph_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [OUT_USER_W-1:0]  m_tuser;
	logic                   m_tlast;

	// pending text bytes and expected glyph transactions
	logic [7:0]    text_q[$];
	glyph_result_t glyph_q[$];
	glyph_result_t want_r;

	// predictor copy of registers and character state
	logic [6:0]  cfg_height = 7'd8;
	logic [6:0]  cfg_width  = 7'd8;
	logic [31:0] ascii_base = '0;
	logic [31:0] extra_base = '0;
	int          need_bytes = 0;
	int          seen_bytes = 0;
	logic [7:0]  lead_b     = '0;
	logic [7:0]  second_b   = '0;
	logic [15:0] char_cnt   = '0;

	// generator bookkeeping
	int gen_left  = 0;
	int gen_bytes = 0;

	int   mismatch_cnt = 0;
	int   cycle_cnt    = 0;
	logic quiet        = 1'b0;
	logic hold_arm     = 1'b0;
	logic hold_done    = 1'b0;
	int   hold_cnt     = 0;

	utf8_glyph_address_mapper_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] text_byte
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [31:0] address, [38:32] index, [54:39] count, [55] zero
		.m_tuser   (m_tuser),   // [0] from_extra_table, [1] replaced_unknown
		.m_tlast   (m_tlast)    // string_end
	);

	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// text byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (text_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 36)) begin
				s_tdata  <= text_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// glyph receiver, with one long hold-off once armed
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1) begin
				hold_done <= 1'b1;
			end
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 36);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// queue one glyph transaction and bump the saturating count
	task automatic push_glyph(input int extra_idx, input logic ascii_ok,
	                          input logic [7:0] ascii_b);
		glyph_result_t r;
		logic [31:0]   base;
		r = '0;
		if (extra_idx >= 0) begin
			r.index = 7'(extra_idx);
			r.extra = 1'b1;
			base    = extra_base;
		end else begin
			if (ascii_ok && ascii_b >= ASCII_FIRST && ascii_b <= ASCII_LAST) begin
				r.index = 7'(ascii_b - ASCII_FIRST);
			end else begin
				r.index    = QMARK_INDEX;
				r.replaced = 1'b1;
			end
			base = ascii_base;
		end
		if (char_cnt != 16'hffff) begin
			char_cnt++;
		end
		r.count   = char_cnt;
		r.address = base + 32'(r.index) * 32'(cfg_height) * 32'(cfg_width);
		glyph_q.push_back(r);
	endtask

	// character assembly for one accepted text byte
	task automatic predict_byte(input logic [7:0] b);
		glyph_result_t r;
		int            found;
		int            k;
		r     = '0;
		found = -1;
		if (need_bytes == 0) begin
			if (b == BYTE_NUL) begin
				r.string_end = 1'b1;
				r.count      = char_cnt;
				char_cnt     = '0;
				glyph_q.push_back(r);
			end else if (!b[7]) begin
				push_glyph(-1, 1'b1, b);
			end else begin
				lead_b     = b;
				need_bytes = !b[5] ? 2 : (!b[4] ? 3 : 4);
				seen_bytes = 1;
			end
		end else begin
			if (seen_bytes == 1) begin
				second_b = b;
			end
			seen_bytes++;
			if (seen_bytes == need_bytes) begin
				if (need_bytes == 2) begin
					for (k = 0; k < PAIR_COUNT; k++) begin
						if (found < 0 && PAIR_TABLE[k] == {lead_b, second_b}) begin
							found = k;
						end
					end
				end else if (need_bytes == 3 && lead_b == INF_LEAD
				             && second_b == INF_SECOND && b == INF_THIRD) begin
					found = INF_INDEX;
				end
				need_bytes = 0;
				seen_bytes = 0;
				push_glyph(found, 1'b0, 8'h00);
			end
		end
	endtask

	// monitor: compare output transactions, then predict from input transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (glyph_q.size() == 0) begin
					$display("%0t: unexpected glyph transaction expected none actual %h %b %b",
					         $time, m_tdata, m_tuser, m_tlast);
					mismatch_cnt++;
				end else begin
					want_r = glyph_q.pop_front();
					check_field("glyph_address", want_r.address, m_tdata[31:0]);
					check_field("glyph_index", 32'(want_r.index), 32'(m_tdata[38:32]));
					check_field("char_count", 32'(want_r.count), 32'(m_tdata[54:39]));
					check_field("tdata pad bit", 32'd0, 32'(m_tdata[55]));
					check_field("from_extra_table", 32'(want_r.extra), 32'(m_tuser[0]));
					check_field("replaced_unknown", 32'(want_r.replaced), 32'(m_tuser[1]));
					check_field("string_end", 32'(want_r.string_end), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata);
			end
		end
	end

	// queue a byte and track where the generated character ends
	task automatic push_text(input logic [7:0] b);
		text_q.push_back(b);
		gen_bytes++;
		if (gen_left > 0) begin
			gen_left--;
		end else if (b[7]) begin
			gen_left = !b[5] ? 1 : (!b[4] ? 2 : 3);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GLYPH_HEIGHT:     cfg_height = val[6:0];
			REG_GLYPH_WIDTH:      cfg_width  = val[6:0];
			REG_ASCII_TABLE_BASE: ascii_base = val;
			REG_EXTRA_TABLE_BASE: extra_base = val;
			default: ;
		endcase
	endtask

	// finish any open character, then wait until all bytes are taken and all glyphs seen
	task automatic drain_text();
		while (gen_left > 0) begin
			push_text(8'($urandom()));
		end
		@(negedge clk);
		while (text_q.size() != 0 || s_tvalid || glyph_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_all(input logic [31:0] h, input logic [31:0] w,
	                         input logic [31:0] ab, input logic [31:0] eb);
		write_reg(REG_GLYPH_HEIGHT, h);
		write_reg(REG_GLYPH_WIDTH, w);
		write_reg(REG_ASCII_TABLE_BASE, ab);
		write_reg(REG_EXTRA_TABLE_BASE, eb);
		@(negedge clk);
	endtask

	// mostly well-formed characters with random content, some broken ones and noise
	task automatic random_text(input int n);
		int         start;
		int         kind;
		logic [7:0] b;
		start = gen_bytes;
		while (gen_bytes - start < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				push_text(8'($urandom_range(32, 126)));
			end else if (kind < 58) begin
				b = 8'($urandom_range(0, PAIR_COUNT - 1));
				push_text(PAIR_TABLE[b][15:8]);
				push_text(PAIR_TABLE[b][7:0]);
			end else if (kind < 65) begin
				push_text(INF_LEAD);
				push_text(INF_SECOND);
				push_text(INF_THIRD);
			end else if (kind < 72) begin
				push_text(BYTE_NUL);
			end else if (kind < 80) begin
				push_text(8'($urandom_range(8'hc0, 8'hdf)));
				push_text(8'($urandom()));
			end else if (kind < 86) begin
				push_text(($urandom_range(0, 1) == 0) ? INF_LEAD
				          : 8'($urandom_range(8'he0, 8'hef)));
				push_text(($urandom_range(0, 1) == 0) ? INF_SECOND : 8'($urandom()));
				push_text(8'($urandom()));
			end else if (kind < 90) begin
				push_text(8'($urandom_range(8'hf0, 8'hff)));
				repeat (3) push_text(8'($urandom()));
			end else if (kind < 94) begin
				push_text(8'($urandom_range(0, 31)));
			end else begin
				push_text(8'($urandom()));
			end
		end
		drain_text();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed text with reset register values
		foreach (DIRECTED_TEXT[i]) begin
			push_text(DIRECTED_TEXT[i]);
		end
		drain_text();

		// one long string of printable characters
		write_all(32'd3, 32'd5, 32'h1000_0000, 32'h2000_0000);
		repeat (LONG_CHARS) push_text(8'($urandom_range(32, 126)));
		push_text(BYTE_NUL);
		drain_text();

		// 64 by 64 glyphs near the top of memory, with the receiver held off at the start
		write_all(32'd64, 32'd64, 32'hffff_fff0, 32'hffff_ff00);
		hold_arm = 1'b1;
		random_text(250);

		// zero height
		write_all(32'd0, 32'($urandom_range(1, 64)), $urandom(), $urandom());
		random_text(240);

		// one by one glyphs and all-ones extra base
		write_all(32'd1, 32'd1, 32'h0000_0000, 32'hffff_ffff);
		random_text(240);

		// zero width, no idling on either side
		write_all(32'($urandom_range(1, 64)), 32'd0, $urandom(), $urandom());
		quiet = 1'b1;
		random_text(240);
		quiet = 1'b0;

		repeat (4) begin
			write_all(32'($urandom_range(1, 64)), 32'($urandom_range(1, 64)),
			          $urandom(), $urandom());
			random_text(245);
		end

		repeat (20) @(negedge clk);
		if (mismatch_cnt == 0 && glyph_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== utf8_glyph_address_mapper_core.f =====
hdl/uga_pkg.sv
hdl/uga_datapath.sv
hdl/uga_controller.sv
hdl/utf8_glyph_address_mapper_core.sv
dv/tb_utf8_glyph_address_mapper_core.sv
